@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SWA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define SWA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and fixed widths of the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int CFG_W            = 11;  // window_len and samples_held
    localparam int SAMPLE_W         = 32;  // sample port
    localparam int AVG_W            = 32;  // average port
    localparam int WINDOW_LEN_RESET = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_START,
        ST_WAIT,
        ST_OUTPUT
    } swa_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIX
    } swa_div_state_t;

    typedef struct packed {
        logic start;
    } swa_div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } swa_div_status_t;

endpackage

@@ design/sliding_window_average.sv @@
// ----------------------------------------------------------------------------
// sliding_window_average
// Moving average over the most recent window_len samples, kept in a ring RAM.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   cfg     | in        | cfg_valid/cfg_ready | cfg_data (window_len)
//   in      | in        | in_valid/in_ready   | sample
//   out     | out       | out_valid/out_ready | average, samples_held
//
// Each item passes through accept, ring read, start, the iterative divider,
// which gives one quotient bit per cycle, sign fix, and the load of the
// output register.
// The output register holds a finished beat while the next sample is taken.
// A stalled output holds the machine before the output load; reset needs no
// clearing pass, as a ring value is only used from slots that hold a sample.
// ----------------------------------------------------------------------------
module sliding_window_average #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swa_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [swa_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [swa_pkg::AVG_W-1:0]     average,
    output logic [swa_pkg::CFG_W-1:0]            samples_held
);

    import swa_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    // one spare bit covers the sum before the oldest sample leaves
    localparam int SUM_W = SAMPLE_BITS + PTR_W + 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    swa_state_t                state_reg, state_next;
    logic [CFG_W-1:0]          window_len_reg, window_len_next;
    logic [PTR_W-1:0]          oldest_ptr_reg, oldest_ptr_next;
    logic [PTR_W-1:0]          next_ptr_reg, next_ptr_next;
    logic [CNT_W-1:0]          held_count_reg, held_count_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                      drop_reg, drop_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [AVG_W-1:0]   average_reg, average_next;
    logic [CFG_W-1:0]          samples_held_reg, samples_held_next;

    logic                      in_beat;
    logic                      out_load;
    logic                      ram_we;
    logic                      ram_re;
    logic [SAMPLE_BITS-1:0]    ram_rdata;
    logic signed [SAMPLE_BITS-1:0] s_ext;
    logic [CMP_W-1:0]          cfg_ext;
    logic [CMP_W-1:0]          held_ext;
    logic [CMP_W-1:0]          limit;
    logic                      drop_now;

    swa_div_ctrl_t             div_ctrl;
    swa_div_status_t           div_status;
    logic signed [SAMPLE_BITS-1:0] quotient;

    // Keep only the low SAMPLE_BITS of the port, sign extended.
    assign s_ext = $signed(sample[SAMPLE_BITS-1:0]);

    // Clamp the window: zero counts as one, above WINDOW_MAX saturates.
    assign cfg_ext  = CMP_W'(window_len_reg);
    assign held_ext = CMP_W'(held_count_reg);
    assign limit    = (cfg_ext == '0) ? CMP_W'(1) :
                      (cfg_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : cfg_ext;
    // Drop the oldest sample when the new one would exceed the window;
    // a shrunk window sheds at most one sample per beat.
    assign drop_now = (held_ext >= limit);

    assign in_beat   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_START;
            ST_START:  if (!div_status.busy) state_next = ST_WAIT;
            ST_WAIT:   if (div_status.done) state_next = ST_OUTPUT;
            ST_OUTPUT: if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        div_ctrl.start = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_FETCH:  ram_we = 1'b1;
            ST_START:  div_ctrl.start = !div_status.busy;
            ST_WAIT:   ;
            ST_OUTPUT: out_load = !out_valid_reg || out_ready;
            default:   ;
        endcase
    end

    // Read the oldest slot on the accept edge; the write of the new sample
    // follows in the next cycle (ST_FETCH), so a full ring reads the old value first.
    assign ram_re = in_beat;

    // Datapath
    always_comb
    begin
        window_len_next   = window_len_reg;
        oldest_ptr_next   = oldest_ptr_reg;
        next_ptr_next     = next_ptr_reg;
        held_count_next   = held_count_reg;
        sum_next          = sum_reg;
        sample_next       = sample_reg;
        drop_next         = drop_reg;
        out_valid_next    = out_valid_reg;
        average_next      = average_reg;
        samples_held_next = samples_held_reg;

        if (cfg_valid && cfg_ready)
        begin
            window_len_next = cfg_data;
        end

        if (in_beat)
        begin
            sample_next = s_ext;
            sum_next    = sum_reg + SUM_W'(s_ext);
            drop_next   = drop_now;
        end

        if (state_reg == ST_FETCH)
        begin
            next_ptr_next = (next_ptr_reg == PTR_W'(WINDOW_MAX - 1)) ?
                            '0 : next_ptr_reg + PTR_W'(1);
            if (drop_reg)
            begin
                sum_next        = sum_reg - SUM_W'($signed(ram_rdata));
                oldest_ptr_next = (oldest_ptr_reg == PTR_W'(WINDOW_MAX - 1)) ?
                                  '0 : oldest_ptr_reg + PTR_W'(1);
            end
            else
            begin
                held_count_next = held_count_reg + CNT_W'(1);
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next    = 1'b1;
            average_next      = AVG_W'(quotient);
            samples_held_next = held_ext[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= CFG_W'(WINDOW_LEN_RESET);
            oldest_ptr_reg <= '0;
            next_ptr_reg   <= '0;
            held_count_reg <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            oldest_ptr_reg <= oldest_ptr_next;
            next_ptr_reg   <= next_ptr_next;
            held_count_reg <= held_count_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg       <= sample_next;
        drop_reg         <= drop_next;
        average_reg      <= average_next;
        samples_held_reg <= samples_held_next;
    end

    swa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (next_ptr_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (oldest_ptr_reg),
        .rdata (ram_rdata)
    );

    swa_divider #(
        .SUM_W  (SUM_W),
        .CNT_W  (CNT_W),
        .QUOT_W (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (sum_reg),
        .divisor  (held_count_reg),
        .status   (div_status),
        .quotient (quotient)
    );

    assign out_valid    = out_valid_reg;
    assign average      = average_reg;
    assign samples_held = samples_held_reg;

endmodule

@@ design/swa_ram.sv @@
// ----------------------------------------------------------------------------
// swa_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/swa_divider.sv @@
// ----------------------------------------------------------------------------
// swa_divider
// Iterative signed divider, one quotient bit per cycle. The dividend is
// known to give a quotient that fits QUOT_W bits, so only QUOT_W steps run.
// ----------------------------------------------------------------------------
module swa_divider #(
    parameter int SUM_W  = 43,
    parameter int CNT_W  = 11,
    parameter int QUOT_W = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swa_pkg::swa_div_ctrl_t        ctrl,
    input  logic signed [SUM_W-1:0]       dividend,
    input  logic [CNT_W-1:0]              divisor,
    output swa_pkg::swa_div_status_t      status,
    output logic signed [QUOT_W-1:0]      quotient
);

    import swa_pkg::*;

    localparam int HI_W   = SUM_W - QUOT_W;
    localparam int REM_W  = HI_W + 1;
    localparam int STEP_W = $clog2(QUOT_W);

    swa_div_state_t     state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [REM_W-1:0]   dvs_reg, dvs_next;
    logic [QUOT_W-1:0]  q_reg, q_next;
    logic               neg_reg, neg_next;
    logic signed [QUOT_W-1:0] quot_reg, quot_next;

    logic [SUM_W-1:0]   mag;
    logic [REM_W-1:0]   shifted;
    logic               fits;

    assign mag     = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
    assign shifted = {rem_reg[REM_W-2:0], q_reg[QUOT_W-1]};
    assign fits    = (shifted >= dvs_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (ctrl.start) state_next = DIV_RUN;
            DIV_RUN:  if (step_reg == '0) state_next = DIV_FIX;
            DIV_FIX:  state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        status.busy = (state_reg != DIV_IDLE);
        status.done = (state_reg == DIV_FIX);
    end

    // datapath
    always_comb
    begin
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        if (state_reg == DIV_IDLE && ctrl.start)
        begin
            // load the high part as the partial remainder, it is below the divisor
            neg_next  = dividend[SUM_W-1];
            rem_next  = {1'b0, mag[SUM_W-1:QUOT_W]};
            q_next    = mag[QUOT_W-1:0];
            dvs_next  = REM_W'(divisor);
            step_next = STEP_W'(QUOT_W - 1);
        end
        else if (state_reg == DIV_RUN)
        begin
            rem_next  = fits ? (shifted - dvs_reg) : shifted;
            q_next    = {q_reg[QUOT_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
        end
        else if (state_reg == DIV_FIX)
        begin
            quot_next = neg_reg ? $signed(~q_reg + QUOT_W'(1)) : $signed(q_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign quotient = quot_reg;

endmodule

@@ design/swa_checker.sv @@
// ----------------------------------------------------------------------------
// swa_checker
// Port-level checks of the sliding window average, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swa_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [swa_pkg::AVG_W-1:0]    average,
    input logic [swa_pkg::CFG_W-1:0]           samples_held
);

    // A result always covers at least the sample that caused it.
    `SWA_ASSERT_IMP(a_held_nonzero, clk, rst_n, out_valid, samples_held != '0)

    // One sample at a time: no second beat right after an accept.
    `SWA_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    // The divider is iterative: no result shows up right after an accept.
    `SWA_ASSERT_NXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

    // A stalled result holds.
    `SWA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(average) && $stable(samples_held))

endmodule

bind sliding_window_average swa_checker u_swa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .average      (average),
    .samples_held (samples_held)
);

@@ tb/sv/sliding_window_average_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_average_checker
// Watches the cfg, in and out channels of the moving average block. It keeps
// its own copy of the sample window and predicts one average beat for every
// accepted sample. It also compares each output beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module sliding_window_average_checker #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [swa_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [swa_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [swa_pkg::AVG_W-1:0]     average,
    input  logic [swa_pkg::CFG_W-1:0]            samples_held,
    output int                                   mismatch_count,
    output int                                   pending_results
);

    typedef struct packed {
        logic signed [swa_pkg::AVG_W-1:0] average;
        logic [swa_pkg::CFG_W-1:0]        samples_held;
    } window_result_t;

    logic signed [swa_pkg::SAMPLE_W-1:0] sample_hist [WINDOW_MAX];
    int unsigned                         oldest_slot;
    int unsigned                         write_slot;
    int unsigned                         held;
    longint                              window_sum;
    logic [swa_pkg::CFG_W-1:0]           window_len;
    window_result_t                      averages_due [$];
    window_result_t                      want;
    int                                  fails;

    // Store the sample, drop the oldest one if the window overflows, and
    // return the truncated mean of what is left.
    function automatic window_result_t push_sample(
        input logic signed [swa_pkg::SAMPLE_W-1:0] s
    );
        int unsigned                         span;
        logic signed [swa_pkg::SAMPLE_W-1:0] leaving;
        longint                              mean;
        window_result_t                      r;
        if (window_len == 0)
            span = 1;
        else if (window_len > WINDOW_MAX)
            span = WINDOW_MAX;
        else
            span = 32'(window_len);
        // Read the oldest slot first; a full ring writes into the same slot.
        leaving = sample_hist[oldest_slot];
        sample_hist[write_slot] = s;
        write_slot = (write_slot + 1) % WINDOW_MAX;
        window_sum += longint'(s);
        held++;
        if (held > span)
        begin
            window_sum -= longint'(leaving);
            oldest_slot = (oldest_slot + 1) % WINDOW_MAX;
            held--;
        end
        mean = window_sum / longint'(held);
        r.average = mean[swa_pkg::AVG_W-1:0];
        r.samples_held = held[swa_pkg::CFG_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_MAX; i++)
                sample_hist[i] = '0;
            oldest_slot = 0;
            write_slot = 0;
            held = 0;
            window_sum = 0;
            window_len = swa_pkg::CFG_W'(swa_pkg::WINDOW_LEN_RESET);
            averages_due.delete();
            fails = 0;
            mismatch_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (averages_due.size() == 0)
                begin
                    $error("output beat with no prediction: average %0d, samples_held %0d",
                           average, samples_held);
                    fails++;
                end
                else
                begin
                    want = averages_due.pop_front();
                    if (average !== want.average)
                    begin
                        $error("average: expected %0d, actual %0d", want.average, average);
                        fails++;
                    end
                    if (samples_held !== want.samples_held)
                    begin
                        $error("samples_held: expected %0d, actual %0d",
                               want.samples_held, samples_held);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                window_len = cfg_data;
            if (in_valid && in_ready)
                averages_due.push_back(push_sample(sample));
            pending_results <= averages_due.size();
            mismatch_count <= fails;
        end
    end

endmodule

@@ tb/sv/tb_sliding_window_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_average
// Drives samples and window lengths into the moving average block with
// random gaps and output stalls. A checker beside the block predicts and
// compares each average beat. This module builds the stimulus and reports
// the verdict.
// ----------------------------------------------------------------------------
module tb_sliding_window_average;

    localparam int WINDOW_MAX    = 1024;
    localparam int SAMPLE_BITS   = 32;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 80;

    localparam logic signed [swa_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [swa_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

    // Shapes the random samples of a run: a broad mix, or heavy on one rail
    // so that the running sum gets pushed toward its extremes.
    typedef enum int {
        MIX_SAMPLES,
        NEAR_MAX,
        NEAR_MIN
    } sample_bias_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [swa_pkg::CFG_W-1:0]           cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [swa_pkg::SAMPLE_W-1:0] sample = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [swa_pkg::AVG_W-1:0]    average;
    logic [swa_pkg::CFG_W-1:0]           samples_held;

    int          mismatch_count;
    int          pending_results;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;      // set to run a stretch with no gaps at all
    int          ready_run = 0;
    int          stall_run = 0;

    sliding_window_average #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .average      (average),
        .samples_held (samples_held)
    );

    sliding_window_average_checker #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .average         (average),
        .samples_held    (samples_held),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: no correct run comes close to this many cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL sliding_window_average");
            $finish;
        end
    end

    // Gap length for either side: mostly back to back, some short holes,
    // now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [swa_pkg::SAMPLE_W-1:0] pick_sample(
        input sample_bias_t bias
    );
        int roll;
        int nudge;
        roll = $urandom_range(0, 99);
        nudge = $urandom_range(0, 200);
        case (bias)
            NEAR_MAX:
            begin
                if (roll < 70)
                    return SAMPLE_MAX;
                if (roll < 85)
                    return SAMPLE_MAX - nudge;
                return $urandom;
            end
            NEAR_MIN:
            begin
                if (roll < 70)
                    return SAMPLE_MIN;
                if (roll < 85)
                    return SAMPLE_MIN + nudge;
                return $urandom;
            end
            default:
            begin
                if (roll < 8)
                    return SAMPLE_MAX;
                if (roll < 16)
                    return SAMPLE_MIN;
                // Small values of both signs exercise truncation toward zero.
                if (roll < 32)
                    return nudge - 100;
                if (roll < 40)
                    return $urandom_range(0, 2) - 1;
                return $urandom;
            end
        endcase
    endfunction

    // Output side: alternate ready stretches with stalls of random length.
    always @(posedge clk)
    begin
        if (stall_run > 0)
        begin
            out_ready <= 1'b0;
            stall_run <= stall_run - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (ready_run > 0)
                ready_run <= ready_run - 1;
            else
            begin
                ready_run <= $urandom_range(0, 12);
                stall_run <= pick_gap();
            end
        end
    end

    // Present one sample beat and hold it until accepted. Keep valid high
    // across back-to-back beats; lower it only when a gap is due.
    task automatic send_sample(input logic signed [swa_pkg::SAMPLE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every predicted average beat has come out.
    // The first edge lets the pending count catch up with the last beat.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Write the window length only with the block idle.
    task automatic set_window(input int unsigned len);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= len[swa_pkg::CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input sample_bias_t bias);
        for (int i = 0; i < count; i++)
            send_sample(pick_sample(bias));
    endtask

    initial
    begin
        int win;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero length acts as a window of one: each average is the sample.
        // Only the very first phase can show this, since held samples never
        // leave faster than new ones arrive.
        set_window(0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(32'sh5555_5555);
        send_sample(32'shAAAA_AAAA);

        // Pairs at the rails, then odd sums of both signs to check that the
        // quotient truncates toward zero.
        set_window(2);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(-3);
        send_sample(-4);
        send_sample(3);
        send_sample(4);

        // Shrink below the held count: samples_held must stay put.
        set_window(1);
        run_random(30, MIX_SAMPLES);

        // Growing windows with a shrink in the middle; every third phase
        // runs without gaps on either side.
        for (int p = 0; p < 8; p++)
        begin
            if (p == 3)
                win = 3;
            else
                win = $urandom_range(4, 24 * (p + 1));
            steady = (p % 3 == 2);
            set_window(win);
            run_random($urandom_range(40, 80), MIX_SAMPLES);
        end
        steady = 1'b0;

        // Full ring: fill all slots, then keep going so the oldest slot is
        // read just as the new sample lands in it. Switch bias per block to
        // drive the sum to both extremes.
        set_window(WINDOW_MAX);
        for (int b = 0; b < 8; b++)
            run_random(150, sample_bias_t'($urandom_range(0, 2)));

        // Lengths above the ring size saturate; 2047 sets every bit.
        set_window(2047);
        run_random(60, MIX_SAMPLES);
        set_window(WINDOW_MAX + 1);
        run_random(40, MIX_SAMPLES);
        set_window(5);
        run_random(40, MIX_SAMPLES);
        set_window($urandom_range(0, 2047));
        run_random(40, MIX_SAMPLES);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS sliding_window_average");
        else
            $display("FAIL sliding_window_average");
        $finish;
    end

endmodule
